@@ hw/rtl/lzss_window_decoder_unit_defines.svh @@
// assertion macros used by the lzss window decoder rtl
`ifndef LZSS_WINDOW_DECODER_UNIT_DEFINES_SVH
`define LZSS_WINDOW_DECODER_UNIT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define LZWD_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define LZWD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// condition never holds
`define LZWD_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

@@ hw/rtl/lzwd_pkg.sv @@
// types, constants and window preset function for the lzss window decoder
`default_nettype none

package lzwd_pkg;

  localparam int WinSize    = 4096;
  localparam int AddrW      = $clog2(WinSize);
  localparam int FillW      = AddrW + 1;
  localparam int ByteW      = 8;
  localparam int LimitW     = 32;
  localparam int CfgIdxW    = 2;
  localparam int LenW       = 4;
  localparam int MatchMin   = 3;
  localparam int MatchMax   = MatchMin + (1 << LenW) - 1;
  localparam int RemW       = $clog2(MatchMax + 1);
  localparam int DefOpDepth  = 4;
  localparam int DefOutDepth = 4;

  localparam logic [CfgIdxW-1:0] CfgLz5Mode   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgLimitEn   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgOutLimit  = 2'd2;

  localparam logic [ByteW-1:0] Space = 8'h20;
  localparam logic [AddrW-1:0] DefaultStart = AddrW'(WinSize - 16);
  localparam logic [AddrW-1:0] Lz5Start     = AddrW'(4078);

  // lz5 preset layout
  localparam logic [AddrW-1:0] Lz5RunBase   = AddrW'(13);
  localparam logic [AddrW-1:0] Lz5UpBase    = AddrW'(3328);
  localparam logic [AddrW-1:0] Lz5DownBase  = AddrW'(3584);
  localparam logic [AddrW-1:0] Lz5DownTop   = AddrW'(3839);
  localparam logic [AddrW-1:0] Lz5ZeroBase  = AddrW'(3840);
  localparam logic [AddrW-1:0] Lz5SpaceBase = AddrW'(3968);
  localparam logic [AddrW-1:0] Lz5SpaceEnd  = AddrW'(4078);

  // divide by 13 as multiply by reciprocal
  localparam int RecipW     = 13;
  localparam int Recip13    = 5042;
  localparam int RecipShift = 16;
  localparam int ProdW      = AddrW + RecipW;

  typedef struct packed {
    logic [ByteW-1:0] in_byte;
    logic             stream_start;
  } in_item_t;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             run_last;
  } out_item_t;

  typedef struct packed {
    logic              en;
    logic [LimitW-1:0] value;
  } limit_cfg_t;

  typedef enum logic [1:0] {
    OP_START,
    OP_LIT,
    OP_MATCH
  } op_kind_e;

  typedef struct packed {
    op_kind_e          kind;
    logic              lz5;
    logic [ByteW-1:0]  data;
    logic [AddrW-1:0]  pos;
    logic [LenW-1:0]   len;
  } op_t;

  function automatic logic [ByteW-1:0] preset_byte(input logic lz5,
                                                   input logic [AddrW-1:0] a);
    logic [AddrW-1:0] x;
    logic [ProdW-1:0] prod;
    logic [ByteW-1:0] v;
    x    = a - Lz5RunBase;
    prod = {{RecipW{1'b0}}, x} * ProdW'(Recip13);
    if (!lz5) begin
      v = Space;
    end else if (a < Lz5RunBase) begin
      v = '0;
    end else if (a < Lz5UpBase) begin
      v = ByteW'(prod[ProdW-1:RecipShift]) + 8'd1;
    end else if (a < Lz5DownBase) begin
      v = ByteW'(a - Lz5UpBase);
    end else if (a < Lz5ZeroBase) begin
      v = ByteW'(Lz5DownTop - a);
    end else if (a < Lz5SpaceBase) begin
      v = '0;
    end else if (a < Lz5SpaceEnd) begin
      v = Space;
    end else begin
      v = '0;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/lzwd_fifo.sv @@
// small register queue used for the token ops and for the output bytes
`default_nettype none

module lzwd_fifo #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [Width-1:0] data_o,
  output logic                  empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             push_ok, pop_ok;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign push_ok = push_i && !full_o;
  assign pop_ok  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_ok) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({push_ok, pop_ok})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/lzwd_front.sv @@
// token parser: turns compressed bytes into start, literal and match ops
`default_nettype none

module lzwd_front import lzwd_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     accept_i,
  input  wire in_item_t item_i,
  input  wire logic     lz5_mode_i,
  output logic          op_push_o,
  output op_t           op_o
);

  typedef enum logic [1:0] {
    PH_CTRL,
    PH_TOKEN,
    PH_MATCH2
  } phase_e;

  phase_e           phase_q, phase_d, phase_cur;
  logic [ByteW-1:0] ctrl_q, ctrl_d;
  logic [2:0]       bit_q, bit_d;
  logic [ByteW-1:0] first_q, first_d;
  logic [ByteW-1:0] b;

  assign b         = item_i.in_byte;
  assign phase_cur = item_i.stream_start ? PH_CTRL : phase_q;

  always_comb begin
    phase_d   = phase_q;
    ctrl_d    = ctrl_q;
    bit_d     = bit_q;
    first_d   = first_q;
    op_push_o = 1'b0;
    op_o      = '0;
    op_o.lz5  = lz5_mode_i;
    if (accept_i) begin
      if (item_i.stream_start) begin
        op_push_o = 1'b1;
        op_o.kind = OP_START;
      end
      unique case (phase_cur)
        PH_CTRL: begin
          ctrl_d  = b;
          bit_d   = '0;
          phase_d = PH_TOKEN;
        end
        PH_TOKEN: begin
          if (ctrl_q[bit_q]) begin
            op_push_o = 1'b1;
            op_o.kind = OP_LIT;
            op_o.data = b;
            bit_d     = bit_q + 1'b1;
            phase_d   = (bit_q == 3'd7) ? PH_CTRL : PH_TOKEN;
          end else begin
            first_d = b;
            phase_d = PH_MATCH2;
          end
        end
        PH_MATCH2: begin
          op_push_o = 1'b1;
          op_o.kind = OP_MATCH;
          op_o.pos  = {b[7:4], first_q};
          op_o.len  = b[3:0];
          bit_d     = bit_q + 1'b1;
          phase_d   = (bit_q == 3'd7) ? PH_CTRL : PH_TOKEN;
        end
        default: phase_d = PH_CTRL;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_CTRL;
      ctrl_q  <= '0;
      bit_q   <= '0;
      first_q <= '0;
    end else begin
      phase_q <= phase_d;
      ctrl_q  <= ctrl_d;
      bit_q   <= bit_d;
      first_q <= first_d;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/lzwd_back.sv @@
// copy engine: window memory, match sequencer, output stage and limit logic
`default_nettype none
`include "lzss_window_decoder_unit_defines.svh"

module lzwd_back import lzwd_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       op_valid_i,
  input  wire op_t        op_i,
  output logic            op_pop_o,
  input  wire limit_cfg_t limit_i,
  input  wire logic       out_full_i,
  output logic            out_push_o,
  output out_item_t       out_item_o
);

  typedef enum logic {
    SEQ_IDLE,
    SEQ_COPY
  } seq_e;

  seq_e              state_q, state_d;
  logic [AddrW-1:0]  rd_pos_q, rd_pos_d;
  logic [RemW-1:0]   remain_q, remain_d;

  logic              mode_q, mode_d;
  logic [AddrW-1:0]  start_pos_q, start_pos_d;
  logic [AddrW-1:0]  wp_q, wp_d;
  logic [FillW-1:0]  fill_q, fill_d;
  logic [LimitW-1:0] bw_q, bw_d;
  logic              stopped_q, stopped_d;

  logic              s2_valid_q, s2_valid_d;
  logic              s2_byp_q, s2_byp_d;
  logic [ByteW-1:0]  s2_data_q, s2_data_d;
  logic              s2_written_q, s2_written_d;
  logic [AddrW-1:0]  s2_addr_q, s2_addr_d;
  logic              s2_last_q, s2_last_d;

  logic [ByteW-1:0]  win_mem [WinSize];
  logic [ByteW-1:0]  rd_data_q;

  logic              s2_fire, s2_free, rd_issue, start_apply, limit_hit;
  logic [ByteW-1:0]  s2_byte;
  logic [AddrW-1:0]  rd_offset;
  logic [AddrW-1:0]  start_sel;

  assign s2_fire   = s2_valid_q && !out_full_i;
  assign s2_free   = !s2_valid_q || s2_fire;
  assign rd_offset = rd_pos_q - start_pos_q;
  assign limit_hit = limit_i.en && (bw_q >= limit_i.value);
  assign start_sel = op_i.lz5 ? Lz5Start : DefaultStart;

  always_comb begin
    if (s2_byp_q) begin
      s2_byte = s2_data_q;
    end else if (s2_written_q) begin
      s2_byte = rd_data_q;
    end else begin
      s2_byte = preset_byte(mode_q, s2_addr_q);
    end
  end

  assign out_push_o          = s2_fire && !stopped_q && !limit_hit;
  assign out_item_o.out_byte = s2_byte;
  assign out_item_o.run_last = s2_last_q ||
                               (limit_i.en && ((bw_q + 32'd1) == limit_i.value));

  always_comb begin
    state_d      = state_q;
    rd_pos_d     = rd_pos_q;
    remain_d     = remain_q;
    op_pop_o     = 1'b0;
    rd_issue     = 1'b0;
    start_apply  = 1'b0;
    s2_valid_d   = s2_fire ? 1'b0 : s2_valid_q;
    s2_byp_d     = s2_byp_q;
    s2_data_d    = s2_data_q;
    s2_written_d = s2_written_q;
    s2_addr_d    = s2_addr_q;
    s2_last_d    = s2_last_q;

    unique case (state_q)
      SEQ_IDLE: begin
        if (op_valid_i) begin
          unique case (op_i.kind)
            OP_START: begin
              if (!s2_valid_q) begin
                start_apply = 1'b1;
                op_pop_o    = 1'b1;
              end
            end
            OP_LIT: begin
              if (s2_free) begin
                op_pop_o     = 1'b1;
                s2_valid_d   = 1'b1;
                s2_byp_d     = 1'b1;
                s2_data_d    = op_i.data;
                s2_written_d = 1'b0;
                s2_last_d    = 1'b1;
              end
            end
            OP_MATCH: begin
              op_pop_o = 1'b1;
              rd_pos_d = op_i.pos;
              remain_d = RemW'(op_i.len) + RemW'(MatchMin);
              state_d  = SEQ_COPY;
            end
            default: op_pop_o = 1'b1;
          endcase
        end
      end
      SEQ_COPY: begin
        if (s2_free) begin
          rd_issue     = 1'b1;
          s2_valid_d   = 1'b1;
          // byte still in the output stage lands on the address being read
          s2_byp_d     = s2_fire && (wp_q == rd_pos_q);
          s2_data_d    = s2_byte;
          s2_written_d = ({1'b0, rd_offset} < fill_q);
          s2_addr_d    = rd_pos_q;
          s2_last_d    = (remain_q == RemW'(1));
          rd_pos_d     = rd_pos_q + 1'b1;
          remain_d     = remain_q - 1'b1;
          if (remain_q == RemW'(1)) begin
            state_d = SEQ_IDLE;
          end
        end
      end
      default: state_d = SEQ_IDLE;
    endcase
  end

  always_comb begin
    mode_d      = mode_q;
    start_pos_d = start_pos_q;
    wp_d        = wp_q;
    fill_d      = fill_q;
    bw_d        = bw_q;
    stopped_d   = stopped_q;
    if (start_apply) begin
      mode_d      = op_i.lz5;
      start_pos_d = start_sel;
      wp_d        = start_sel;
      fill_d      = '0;
      bw_d        = '0;
      stopped_d   = 1'b0;
    end else if (s2_fire) begin
      wp_d = wp_q + 1'b1;
      if (fill_q != FillW'(WinSize)) begin
        fill_d = fill_q + 1'b1;
      end
      if (!stopped_q) begin
        if (limit_hit) begin
          stopped_d = 1'b1;
        end else begin
          bw_d = bw_q + 32'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= SEQ_IDLE;
      rd_pos_q     <= '0;
      remain_q     <= '0;
      mode_q       <= 1'b0;
      start_pos_q  <= DefaultStart;
      wp_q         <= DefaultStart;
      fill_q       <= '0;
      bw_q         <= '0;
      stopped_q    <= 1'b0;
      s2_valid_q   <= 1'b0;
      s2_byp_q     <= 1'b0;
      s2_data_q    <= '0;
      s2_written_q <= 1'b0;
      s2_addr_q    <= '0;
      s2_last_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      rd_pos_q     <= rd_pos_d;
      remain_q     <= remain_d;
      mode_q       <= mode_d;
      start_pos_q  <= start_pos_d;
      wp_q         <= wp_d;
      fill_q       <= fill_d;
      bw_q         <= bw_d;
      stopped_q    <= stopped_d;
      s2_valid_q   <= s2_valid_d;
      s2_byp_q     <= s2_byp_d;
      s2_data_q    <= s2_data_d;
      s2_written_q <= s2_written_d;
      s2_addr_q    <= s2_addr_d;
      s2_last_q    <= s2_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_fire) begin
      win_mem[wp_q] <= s2_byte;
    end
    if (rd_issue) begin
      rd_data_q <= win_mem[rd_pos_q];
    end
  end

  `LZWD_ASSERT_IMPLIES(a_issue_slot, rd_issue, !s2_valid_q || s2_fire, "read issued into busy stage")
  `LZWD_ASSERT_NEXT(a_start_clears, start_apply, (fill_q == '0) && (bw_q == '0) && !stopped_q, "stream start did not clear counters")
  `LZWD_ASSERT_NEXT(a_stop_sticky, stopped_q && !start_apply, stopped_q, "stop released without stream start")
  `LZWD_ASSERT_NEVER(a_fill_bound, fill_q > FillW'(WinSize), "fill count beyond window")
  `LZWD_ASSERT_IMPLIES(a_emit_limit, out_push_o && limit_i.en, bw_q < limit_i.value, "byte emitted past limit")

endmodule

`default_nettype wire

@@ hw/rtl/lzss_window_decoder_unit.sv @@
// top level of the lzss window decoder: config registers, queues, front and back
//
//  channel   | handshake            | payload
//  ----------+----------------------+--------------------------------
//  input     | push / full          | item_i   (in_byte, stream_start)
//  result    | pop / empty          | result_o (out_byte, run_last)
//  config    | cfg_valid_i / ready  | cfg_index_i, cfg_data_i
//
//  the parser takes one compressed byte per cycle while the op queue has room
//  the copy engine passes each literal straight to the output stage and copies a match with
//  one window read per cycle while the output stage is free; control bytes give the back end no op
//  a stream start waits for the output stage to drain
//  window presets come from a fill count, so reset and stream start need no clearing pass
//  a full result queue stalls the copy engine, a full op queue raises full
`default_nettype none

module lzss_window_decoder_unit import lzwd_pkg::*; #(
  parameter int OpDepth  = DefOpDepth,
  parameter int OutDepth = DefOutDepth
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  output logic                    full,
  input  wire in_item_t           item_i,
  output logic                    empty,
  input  wire logic               pop,
  output out_item_t               result_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [LimitW-1:0]  cfg_data_i
);

  logic              lz5_q;
  logic              limit_en_q;
  logic [LimitW-1:0] limit_q;
  limit_cfg_t        limit_cfg;

  logic      accept;
  logic      op_push, op_valid, op_empty, op_pop;
  op_t       op_in, op_out;
  logic      out_push, out_full;
  out_item_t out_item;

  assign cfg_ready_o     = 1'b1;
  assign accept          = push && !full;
  assign op_valid        = !op_empty;
  assign limit_cfg.en    = limit_en_q;
  assign limit_cfg.value = limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lz5_q      <= 1'b0;
      limit_en_q <= 1'b0;
      limit_q    <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgLz5Mode:  lz5_q      <= cfg_data_i[0];
        CfgLimitEn:  limit_en_q <= cfg_data_i[0];
        CfgOutLimit: limit_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  lzwd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .item_i     (item_i),
    .lz5_mode_i (lz5_q),
    .op_push_o  (op_push),
    .op_o       (op_in)
  );

  lzwd_fifo #(
    .Width ($bits(op_t)),
    .Depth (OpDepth)
  ) u_op_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (op_push),
    .data_i  (op_in),
    .full_o  (full),
    .pop_i   (op_pop),
    .data_o  (op_out),
    .empty_o (op_empty)
  );

  lzwd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (op_valid),
    .op_i       (op_out),
    .op_pop_o   (op_pop),
    .limit_i    (limit_cfg),
    .out_full_i (out_full),
    .out_push_o (out_push),
    .out_item_o (out_item)
  );

  lzwd_fifo #(
    .Width ($bits(out_item_t)),
    .Depth (OutDepth)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (out_item),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (result_o),
    .empty_o (empty)
  );

endmodule

`default_nettype wire
